FILE: hdl/pmfa_pkg.sv
// ---------------------------------------------------------------------------
// pmfa_pkg
// Shared types and constants for the particulate sensor frame averager.
// ---------------------------------------------------------------------------
package pmfa_pkg;

    // Input opcodes
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_FINALIZE = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_GOOD  = 2'd0;
    localparam logic [1:0] KIND_BAD   = 2'd1;
    localparam logic [1:0] KIND_VALID = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // Frame framing bytes
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hC0;
    localparam logic [7:0] TAIL_BYTE  = 8'hAB;

    // Parser phases: searching, AA seen, body bytes 0..7
    localparam logic [3:0] PH_SEARCH = 4'd0;
    localparam logic [3:0] PH_HDR    = 4'd1;
    localparam logic [3:0] PH_BODY0  = 4'd2;
    localparam logic [3:0] PH_LAST   = 4'd9;

    // Window accumulator limits
    localparam logic [9:0]  MAX_SAMPLES = 10'd1023;
    localparam logic [15:0] LOW_RESET   = 16'd20000;
    localparam logic [15:0] ERR_MAX     = 16'hFFFF;

    // Widths
    localparam int SUM_W  = 26;
    localparam int VAL_W  = 20;
    localparam int CNT_W  = 10;
    localparam int ERR_W  = 16;
    localparam int DIVD_W = SUM_W + 4;   // sum times ten

    // Command queue between parser and accumulator
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Work handed from the parser to the accumulator
    typedef struct packed {
        logic        is_final;
        logic        good;
        logic        win;
        logic [15:0] p10;
        logic [15:0] p25;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] pm10;
        logic [VAL_W-1:0] pm25;
        logic [CNT_W-1:0] cnt;
        logic [ERR_W-1:0] err;
    } res_t;

endpackage

FILE: hdl/pmfa_front.sv
// ---------------------------------------------------------------------------
// pmfa_front
// Header hunt, body capture and frame check; hands frames and finalize
// requests to the command queue.
// ---------------------------------------------------------------------------
module pmfa_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          opcode,
    input  logic [7:0]          rx_byte,
    input  logic                in_window,
    output logic                cmd_push,
    output pmfa_pkg::cmd_t      cmd
);

    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [3:0] phase_cur;
    logic [7:0] body_reg [0:6];
    logic [2:0] body_idx;
    logic [7:0] cks;
    logic       frame_done;
    logic       body_wr;

    // Out-of-range phases count as searching
    assign phase_cur = (phase_reg > pmfa_pkg::PH_LAST) ? pmfa_pkg::PH_SEARCH : phase_reg;
    assign body_idx  = 3'(phase_cur - pmfa_pkg::PH_BODY0);

    // Parser next phase
    always_comb
    begin
        phase_next = phase_reg;
        frame_done = 1'b0;
        body_wr    = 1'b0;
        if (accept)
        begin
            unique case (opcode)
                pmfa_pkg::OP_BYTE:
                begin
                    priority if (phase_cur == pmfa_pkg::PH_SEARCH)
                    begin
                        phase_next = (rx_byte == pmfa_pkg::HDR_FIRST) ?
                                     pmfa_pkg::PH_HDR : pmfa_pkg::PH_SEARCH;
                    end
                    else if (phase_cur == pmfa_pkg::PH_HDR)
                    begin
                        priority if (rx_byte == pmfa_pkg::HDR_SECOND)
                            phase_next = pmfa_pkg::PH_BODY0;
                        else if (rx_byte == pmfa_pkg::HDR_FIRST)
                            phase_next = pmfa_pkg::PH_HDR;
                        else
                            phase_next = pmfa_pkg::PH_SEARCH;
                    end
                    else if (phase_cur == pmfa_pkg::PH_LAST)
                    begin
                        phase_next = pmfa_pkg::PH_SEARCH;
                        frame_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_cur + 4'd1;
                        body_wr    = 1'b1;
                    end
                end
                pmfa_pkg::OP_RESTART: phase_next = pmfa_pkg::PH_SEARCH;
                pmfa_pkg::OP_FINALIZE,
                pmfa_pkg::OP_UNUSED: phase_next = phase_reg;
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Checksum of body bytes 0..5, 8-bit wrap
    assign cks = body_reg[0] + body_reg[1] + body_reg[2]
               + body_reg[3] + body_reg[4] + body_reg[5];

    // Command to the back end
    always_comb
    begin
        cmd.is_final = (opcode == pmfa_pkg::OP_FINALIZE);
        cmd.good     = (cks == body_reg[6]) && (rx_byte == pmfa_pkg::TAIL_BYTE);
        cmd.win      = in_window;
        cmd.p25      = {body_reg[1], body_reg[0]};
        cmd.p10      = {body_reg[3], body_reg[2]};
        cmd_push     = frame_done || (accept && opcode == pmfa_pkg::OP_FINALIZE);
    end

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= pmfa_pkg::PH_SEARCH;
        else
            phase_reg <= phase_next;
    end

    // Body bytes, no reset
    always_ff @(posedge clk)
    begin
        if (body_wr)
            body_reg[body_idx] <= rx_byte;
    end

endmodule

FILE: hdl/pmfa_queue.sv
// ---------------------------------------------------------------------------
// pmfa_queue
// Short command queue between the parser and the accumulator.
// ---------------------------------------------------------------------------
module pmfa_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pmfa_pkg::cmd_t      wr_data,
    input  logic                pop,
    output pmfa_pkg::cmd_t      rd_data,
    output logic                full,
    output logic                empty
);

    pmfa_pkg::cmd_t                  mem_reg [0:pmfa_pkg::QUEUE_DEPTH-1];
    logic [pmfa_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [pmfa_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [pmfa_pkg::QPTR_W:0]       count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == (pmfa_pkg::QPTR_W+1)'(pmfa_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hdl/pmfa_div.sv
// ---------------------------------------------------------------------------
// pmfa_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pmfa_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pmfa_pkg::DIVD_W-1:0]     dividend,
    input  logic [pmfa_pkg::CNT_W-1:0]      divisor,
    output logic                            done,
    output logic [pmfa_pkg::VAL_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(pmfa_pkg::DIVD_W);

    logic                            busy_reg;
    logic                            done_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [pmfa_pkg::CNT_W-1:0]      dsr_reg;
    logic [pmfa_pkg::CNT_W-1:0]      rem_reg;
    logic [pmfa_pkg::DIVD_W-1:0]     quo_reg;
    logic [pmfa_pkg::CNT_W:0]        rem_shift;
    logic [pmfa_pkg::CNT_W:0]        rem_diff;
    logic                            q_bit;

    // One trial subtract
    assign rem_shift = {rem_reg, quo_reg[pmfa_pkg::DIVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign q_bit     = (rem_shift >= {1'b0, dsr_reg});

    assign done     = done_reg;
    assign quotient = quo_reg[pmfa_pkg::VAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= q_bit ? rem_diff[pmfa_pkg::CNT_W-1:0]
                                 : rem_shift[pmfa_pkg::CNT_W-1:0];
                quo_reg <= {quo_reg[pmfa_pkg::DIVD_W-2:0], q_bit};
                if (step_reg == STEP_W'(pmfa_pkg::DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/pmfa_back.sv
// ---------------------------------------------------------------------------
// pmfa_back
// Window accumulator: sums, min/max, finalize with an average (min and max trimmed
// above two samples) and error count; holds the result register.
// ---------------------------------------------------------------------------
module pmfa_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  pmfa_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic                res_pop,
    output logic                res_valid,
    output pmfa_pkg::res_t      res
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_START,
        ST_DIV
    } state_t;

    state_t                          state_reg;
    logic [pmfa_pkg::SUM_W-1:0]      pm10_sum_reg;
    logic [pmfa_pkg::SUM_W-1:0]      pm25_sum_reg;
    logic [15:0]                     pm10_low_reg;
    logic [15:0]                     pm10_high_reg;
    logic [15:0]                     pm25_low_reg;
    logic [15:0]                     pm25_high_reg;
    logic [pmfa_pkg::CNT_W-1:0]      count_reg;
    logic [pmfa_pkg::ERR_W-1:0]      err_reg;
    logic [pmfa_pkg::SUM_W-1:0]      s10_reg;
    logic [pmfa_pkg::SUM_W-1:0]      s25_reg;
    logic [pmfa_pkg::CNT_W-1:0]      n_reg;
    logic                            res_valid_reg;
    pmfa_pkg::res_t                  res_reg;

    logic                            slot_free;
    logic                            take;
    logic                            acc_en;
    logic                            trim;
    logic [pmfa_pkg::ERR_W-1:0]      err_bump;
    logic [pmfa_pkg::DIVD_W-1:0]     d10;
    logic [pmfa_pkg::DIVD_W-1:0]     d25;
    logic                            div_start;
    logic                            done10;
    logic                            done25;
    logic [pmfa_pkg::VAL_W-1:0]      q10;
    logic [pmfa_pkg::VAL_W-1:0]      q25;

    // Result slot and command handshake
    assign slot_free = !res_valid_reg || res_pop;
    assign take      = (state_reg == ST_IDLE) && !cmd_empty && slot_free;
    assign cmd_pop   = take;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign acc_en   = cmd.good && cmd.win && (count_reg < pmfa_pkg::MAX_SAMPLES);
    assign trim     = (count_reg > pmfa_pkg::CNT_W'(2));
    assign err_bump = (err_reg != pmfa_pkg::ERR_MAX) ? err_reg + 1'b1 : err_reg;

    // Dividends: trimmed sum times ten
    assign d10       = ({4'b0, s10_reg} << 3) + ({4'b0, s10_reg} << 1);
    assign d25       = ({4'b0, s25_reg} << 3) + ({4'b0, s25_reg} << 1);
    assign div_start = (state_reg == ST_START) && (n_reg != '0);

    pmfa_div u_div10
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d10),
        .divisor  (n_reg),
        .done     (done10),
        .quotient (q10)
    );

    pmfa_div u_div25
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d25),
        .divisor  (n_reg),
        .done     (done25),
        .quotient (q25)
    );

    // Sequencer, accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pm10_sum_reg  <= '0;
            pm25_sum_reg  <= '0;
            pm10_low_reg  <= pmfa_pkg::LOW_RESET;
            pm10_high_reg <= '0;
            pm25_low_reg  <= pmfa_pkg::LOW_RESET;
            pm25_high_reg <= '0;
            count_reg     <= '0;
            err_reg       <= '0;
            s10_reg       <= '0;
            s25_reg       <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_pop)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take && !cmd.is_final)
                    begin
                        // Frame result, accumulate when good, in window and below the sample limit
                        if (acc_en)
                        begin
                            pm10_sum_reg <= pm10_sum_reg + pmfa_pkg::SUM_W'(cmd.p10);
                            pm25_sum_reg <= pm25_sum_reg + pmfa_pkg::SUM_W'(cmd.p25);
                            if (cmd.p10 < pm10_low_reg)
                                pm10_low_reg <= cmd.p10;
                            if (cmd.p10 > pm10_high_reg)
                                pm10_high_reg <= cmd.p10;
                            if (cmd.p25 < pm25_low_reg)
                                pm25_low_reg <= cmd.p25;
                            if (cmd.p25 > pm25_high_reg)
                                pm25_high_reg <= cmd.p25;
                            count_reg <= count_reg + 1'b1;
                        end
                        res_valid_reg <= 1'b1;
                        res_reg.kind  <= cmd.good ? pmfa_pkg::KIND_GOOD : pmfa_pkg::KIND_BAD;
                        res_reg.pm10  <= pmfa_pkg::VAL_W'(cmd.p10);
                        res_reg.pm25  <= pmfa_pkg::VAL_W'(cmd.p25);
                        res_reg.cnt   <= '0;
                        res_reg.err   <= err_reg;
                    end
                    else if (take)
                    begin
                        // Finalize: capture sums (trimmed above two samples), clear the window
                        if (trim)
                        begin
                            s10_reg <= pm10_sum_reg - pmfa_pkg::SUM_W'({1'b0, pm10_low_reg}
                                                                        + {1'b0, pm10_high_reg});
                            s25_reg <= pm25_sum_reg - pmfa_pkg::SUM_W'({1'b0, pm25_low_reg}
                                                                        + {1'b0, pm25_high_reg});
                            n_reg   <= count_reg - pmfa_pkg::CNT_W'(2);
                        end
                        else
                        begin
                            s10_reg <= pm10_sum_reg;
                            s25_reg <= pm25_sum_reg;
                            n_reg   <= count_reg;
                        end
                        pm10_sum_reg  <= '0;
                        pm25_sum_reg  <= '0;
                        pm10_low_reg  <= pmfa_pkg::LOW_RESET;
                        pm10_high_reg <= '0;
                        pm25_low_reg  <= pmfa_pkg::LOW_RESET;
                        pm25_high_reg <= '0;
                        count_reg     <= '0;
                        state_reg     <= ST_START;
                    end
                end
                ST_START:
                begin
                    if (n_reg == '0)
                    begin
                        // Empty window
                        err_reg       <= err_bump;
                        res_valid_reg <= 1'b1;
                        res_reg.kind  <= pmfa_pkg::KIND_EMPTY;
                        res_reg.pm10  <= '0;
                        res_reg.pm25  <= '0;
                        res_reg.cnt   <= '0;
                        res_reg.err   <= err_bump;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (done10 && done25)
                    begin
                        // Fewer than three used samples counts as an error window
                        if (n_reg < pmfa_pkg::CNT_W'(3))
                        begin
                            err_reg     <= err_bump;
                            res_reg.err <= err_bump;
                        end
                        else
                        begin
                            res_reg.err <= err_reg;
                        end
                        res_valid_reg <= 1'b1;
                        res_reg.kind  <= pmfa_pkg::KIND_VALID;
                        res_reg.pm10  <= q10;
                        res_reg.pm25  <= q25;
                        res_reg.cnt   <= n_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/pm_sensor_frame_averager.sv
// A frame result passes the command queue and result register once its last byte
// is taken; a finalize also passes the start state and, for a non-empty window,
// the 30-step serial divider, which holds the accumulator. Throughput: one item
// per cycle into a 4-entry command queue while full is low; frames drain at one
// per cycle while results are popped. Reset (rst_n, async, active low) sets the
// parser to header search, clears sums, count, errors and all queues.
// ---------------------------------------------------------------------------
// pm_sensor_frame_averager
// Parses particulate sensor reply frames and averages them over a window.
// ---------------------------------------------------------------------------
module pm_sensor_frame_averager
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    input  logic        in_window,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [19:0] pm10_value,
    output logic [19:0] pm25_value,
    output logic [9:0]  sample_count,
    output logic [15:0] error_total
);

    pmfa_pkg::cmd_t cmd_in;
    pmfa_pkg::cmd_t cmd_out;
    pmfa_pkg::res_t res;
    logic           accept;
    logic           cmd_push;
    logic           cmd_pop;
    logic           q_full;
    logic           q_empty;
    logic           res_valid;

    // Input handshake
    assign full   = q_full;
    assign accept = push && !q_full;

    pmfa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .in_window (in_window),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    pmfa_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    pmfa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_pop   (pop && res_valid),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result ports
    assign empty        = !res_valid;
    assign kind         = res.kind;
    assign pm10_value   = res.pm10;
    assign pm25_value   = res.pm25;
    assign sample_count = res.cnt;
    assign error_total  = res.err;

endmodule

FILE: hdl/pmfa_checker.sv
// ---------------------------------------------------------------------------
// pmfa_checker
// Port-level checks on the result queue of the frame averager.
// ---------------------------------------------------------------------------
module pmfa_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  kind,
    input  logic [19:0] pm10_value,
    input  logic [19:0] pm25_value,
    input  logic [9:0]  sample_count,
    input  logic [15:0] error_total
);

    // A waiting item holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(pm10_value)
                              && $stable(pm25_value) && $stable(sample_count)
                              && $stable(error_total)))
        else $error("result item changed while waiting");

    // Frame items carry no sample count
    a_frame_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == pmfa_pkg::KIND_GOOD || kind == pmfa_pkg::KIND_BAD))
        |-> (sample_count == '0))
        else $error("frame item with nonzero sample count");

    // Empty window summary has zero values and count and a nonzero error total
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == pmfa_pkg::KIND_EMPTY)
        |-> (pm10_value == '0 && pm25_value == '0 && sample_count == '0
             && error_total != '0))
        else $error("empty summary with nonzero payload");

    // Valid summary uses at least one sample
    a_valid_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == pmfa_pkg::KIND_VALID) |-> (sample_count != '0))
        else $error("valid summary with zero samples");

endmodule

bind pm_sensor_frame_averager pmfa_checker u_pmfa_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .pm10_value   (pm10_value),
    .pm25_value   (pm25_value),
    .sample_count (sample_count),
    .error_total  (error_total)
);

FILE: test/pm_sensor_frame_averager_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pm_sensor_frame_averager_tb
// Self-checking bench for the sensor frame parser and window averager. A
// scoreboard keeps its own copy of the parser and window state and predicts
// every result; stimulus covers header hunting, good and bad frames, restarts,
// window trimming, empty and short windows and a long receiver stall.
// ---------------------------------------------------------------------------
module pm_sensor_frame_averager_tb;

    localparam int STALL_LIMIT  = 5000;   // cycles with no item moving
    localparam int HOLD_CYCLES  = 600;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;     // finalize latency plus margin
    localparam int RANDOM_ITEMS = 360;
    localparam int CALM_ITEMS   = 150;    // opening random stretch, no idling

    // Predicts frame and window results and checks them in order
    class pm_window_scoreboard;
        logic [3:0]                 phase;
        logic [7:0][7:0]            body;
        logic [pmfa_pkg::SUM_W-1:0] pm10_sum;
        logic [pmfa_pkg::SUM_W-1:0] pm25_sum;
        logic [15:0]                pm10_low;
        logic [15:0]                pm10_high;
        logic [15:0]                pm25_low;
        logic [15:0]                pm25_high;
        logic [pmfa_pkg::CNT_W-1:0] samples;
        logic [pmfa_pkg::ERR_W-1:0] win_errors;
        pmfa_pkg::res_t             expected_q[$];
        int unsigned                items;
        int unsigned                checked;
        int unsigned                mismatches;
        int unsigned                good_frames;
        int unsigned                bad_frames;
        int unsigned                valid_windows;
        int unsigned                empty_windows;

        function new();
            phase         = pmfa_pkg::PH_SEARCH;
            body          = '0;
            win_errors    = '0;
            items         = 0;
            checked       = 0;
            mismatches    = 0;
            good_frames   = 0;
            bad_frames    = 0;
            valid_windows = 0;
            empty_windows = 0;
            clear_window();
        endfunction

        function void clear_window();
            pm10_sum  = '0;
            pm25_sum  = '0;
            pm10_low  = pmfa_pkg::LOW_RESET;
            pm10_high = '0;
            pm25_low  = pmfa_pkg::LOW_RESET;
            pm25_high = '0;
            samples   = '0;
        endfunction

        // Update state for one accepted item and queue its result, if any
        function void note_item(logic [1:0] op, logic [7:0] b, logic win);
            logic [3:0]                 ph;
            logic [2:0]                 bi;
            logic [7:0]                 ck;
            logic [15:0]                p10;
            logic [15:0]                p25;
            logic                       ok;
            logic [63:0]                s10;
            logic [63:0]                s25;
            logic [pmfa_pkg::CNT_W-1:0] n;
            pmfa_pkg::res_t             r;
            items++;
            ph = (phase > pmfa_pkg::PH_LAST) ? pmfa_pkg::PH_SEARCH : phase;
            case (op)
                pmfa_pkg::OP_BYTE:
                begin
                    if (ph == pmfa_pkg::PH_SEARCH)
                    begin
                        phase = (b == pmfa_pkg::HDR_FIRST) ? pmfa_pkg::PH_HDR
                                                           : pmfa_pkg::PH_SEARCH;
                    end
                    else if (ph == pmfa_pkg::PH_HDR)
                    begin
                        if (b == pmfa_pkg::HDR_SECOND)
                            phase = pmfa_pkg::PH_BODY0;
                        else if (b == pmfa_pkg::HDR_FIRST)
                            phase = pmfa_pkg::PH_HDR;
                        else
                            phase = pmfa_pkg::PH_SEARCH;
                    end
                    else
                    begin
                        bi       = 3'(ph - pmfa_pkg::PH_BODY0);
                        body[bi] = b;
                        if (ph != pmfa_pkg::PH_LAST)
                        begin
                            phase = ph + 4'd1;
                        end
                        else
                        begin
                            // Whole body in: check it and maybe accumulate
                            phase = pmfa_pkg::PH_SEARCH;
                            ck  = body[0] + body[1] + body[2] + body[3] + body[4] + body[5];
                            ok  = (ck == body[6]) && (body[7] == pmfa_pkg::TAIL_BYTE);
                            p25 = {body[1], body[0]};
                            p10 = {body[3], body[2]};
                            if (ok && win && samples < pmfa_pkg::MAX_SAMPLES)
                            begin
                                pm10_sum = pm10_sum + pmfa_pkg::SUM_W'(p10);
                                pm25_sum = pm25_sum + pmfa_pkg::SUM_W'(p25);
                                if (p10 < pm10_low)  pm10_low  = p10;
                                if (p10 > pm10_high) pm10_high = p10;
                                if (p25 < pm25_low)  pm25_low  = p25;
                                if (p25 > pm25_high) pm25_high = p25;
                                samples++;
                            end
                            r.kind = ok ? pmfa_pkg::KIND_GOOD : pmfa_pkg::KIND_BAD;
                            r.pm10 = pmfa_pkg::VAL_W'(p10);
                            r.pm25 = pmfa_pkg::VAL_W'(p25);
                            r.cnt  = '0;
                            r.err  = win_errors;
                            if (ok) good_frames++;
                            else    bad_frames++;
                            expected_q.push_back(r);
                        end
                    end
                end
                pmfa_pkg::OP_FINALIZE:
                begin
                    // Trim min and max once more than two samples exist
                    s10 = 64'(pm10_sum);
                    s25 = 64'(pm25_sum);
                    n   = samples;
                    if (n > pmfa_pkg::CNT_W'(2))
                    begin
                        s10 = s10 - 64'(pm10_low) - 64'(pm10_high);
                        s25 = s25 - 64'(pm25_low) - 64'(pm25_high);
                        n   = n - pmfa_pkg::CNT_W'(2);
                    end
                    if (n != '0)
                    begin
                        if (n < pmfa_pkg::CNT_W'(3) && win_errors != pmfa_pkg::ERR_MAX)
                            win_errors++;
                        r.kind = pmfa_pkg::KIND_VALID;
                        r.pm10 = pmfa_pkg::VAL_W'((s10 * 64'd10) / 64'(n));
                        r.pm25 = pmfa_pkg::VAL_W'((s25 * 64'd10) / 64'(n));
                        r.cnt  = n;
                        valid_windows++;
                    end
                    else
                    begin
                        if (win_errors != pmfa_pkg::ERR_MAX)
                            win_errors++;
                        r.kind = pmfa_pkg::KIND_EMPTY;
                        r.pm10 = '0;
                        r.pm25 = '0;
                        r.cnt  = '0;
                        empty_windows++;
                    end
                    r.err = win_errors;
                    expected_q.push_back(r);
                    clear_window();
                end
                pmfa_pkg::OP_RESTART:
                begin
                    phase = pmfa_pkg::PH_SEARCH;
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(pmfa_pkg::res_t got);
            pmfa_pkg::res_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR %0t: unexpected result ",
                              "kind=%0d pm10=%0d pm25=%0d cnt=%0d err=%0d"},
                             $time, got.kind, got.pm10, got.pm25, got.cnt, got.err);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.pm10 !== want.pm10 || got.pm25 !== want.pm25 ||
                got.cnt !== want.cnt || got.err !== want.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR %0t: result %0d mismatch", $time, checked);
                    $display("  expected kind=%0d pm10=%0d pm25=%0d cnt=%0d err=%0d",
                             want.kind, want.pm10, want.pm25, want.cnt, want.err);
                    $display("  actual   kind=%0d pm10=%0d pm25=%0d cnt=%0d err=%0d",
                             got.kind, got.pm10, got.pm25, got.cnt, got.err);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic        in_window;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [19:0] pm10_value;
    logic [19:0] pm25_value;
    logic [9:0]  sample_count;
    logic [15:0] error_total;

    pm_window_scoreboard sb;
    bit          send_idles  = 1'b0;
    bit          recv_idles  = 1'b0;
    int          hold_left   = 0;
    int unsigned sent_count  = 0;
    int unsigned quiet_count = 0;

    pm_sensor_frame_averager u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .in_window    (in_window),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .pm10_value   (pm10_value),
        .pm25_value   (pm25_value),
        .sample_count (sample_count),
        .error_total  (error_total)
    );

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic win);
        while (send_idles && $urandom_range(0, 99) < 19)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        opcode    <= op;
        rx_byte   <= b;
        in_window <= win;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (op != pmfa_pkg::OP_UNUSED)
            sent_count++;
    endtask

    // Header, body and tail of one frame; win matters on the last byte only
    task automatic send_frame(input logic [15:0] p25, input logic [15:0] p10,
                              input logic ck_ok, input logic tail_ok, input logic win);
        logic [7:0][7:0] fb;
        logic [7:0]      flip;
        int              i;
        fb[0] = p25[7:0];
        fb[1] = p25[15:8];
        fb[2] = p10[7:0];
        fb[3] = p10[15:8];
        fb[4] = 8'($urandom);
        fb[5] = 8'($urandom);
        fb[6] = fb[0] + fb[1] + fb[2] + fb[3] + fb[4] + fb[5];
        flip  = 8'($urandom_range(1, 255));
        if (!ck_ok)
            fb[6] = fb[6] ^ flip;
        fb[7] = 8'($urandom);
        if (tail_ok)
            fb[7] = pmfa_pkg::TAIL_BYTE;
        else if (fb[7] == pmfa_pkg::TAIL_BYTE)
            fb[7] = ~pmfa_pkg::TAIL_BYTE;
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_FIRST, 1'($urandom_range(0, 1)));
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_SECOND, 1'($urandom_range(0, 1)));
        for (i = 0; i < 7; i++)
            send_item(pmfa_pkg::OP_BYTE, fb[i], 1'($urandom_range(0, 1)));
        send_item(pmfa_pkg::OP_BYTE, fb[7], win);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // PM level in tenths: often small, with the 16-bit extremes
    function automatic logic [15:0] pick_level();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 16'hFFFF;
        if (sel < 18)
            return 16'h0000;
        if (sel < 60)
            return 16'($urandom_range(0, 500));
        return 16'($urandom);
    endfunction

    // Receiver: random pops, plus a long hold-off on request
    initial
    begin : receiver
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= !(recv_idles && $urandom_range(0, 99) < 19);
            end
        end
    end

    // Handshake monitor and watchdog
    always @(posedge clk)
    begin : monitor
        pmfa_pkg::res_t seen;
        if (rst_n)
        begin
            seen = {kind, pm10_value, pm25_value, sample_count, error_total};
            if (push && !full)
                sb.note_item(opcode, rx_byte, in_window);
            if (pop && !empty)
                sb.check_result(seen);
            if ((push && !full) || (pop && !empty))
            begin
                quiet_count = 0;
            end
            else
            begin
                quiet_count++;
                if (quiet_count >= STALL_LIMIT)
                begin
                    $display("Watchdog: no item moved for %0d cycles at %0t",
                             STALL_LIMIT, $time);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned sel;
        int unsigned k;
        logic [7:0]  nb;
        sb        = new();
        rst_n     = 1'b0;
        push      = 1'b0;
        opcode    = pmfa_pkg::OP_BYTE;
        rx_byte   = 8'h00;
        in_window = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unused opcode, empty window, AA AA C0, extreme values,
        // single-sample window, broken header, restart mid-frame, bad tail
        send_item(pmfa_pkg::OP_UNUSED, 8'hFF, 1'b1);
        send_item(pmfa_pkg::OP_FINALIZE, 8'h00, 1'b0);
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_FIRST, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1);
        send_item(pmfa_pkg::OP_FINALIZE, 8'h00, 1'b1);
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_FIRST, 1'b1);
        send_item(pmfa_pkg::OP_BYTE, 8'h55, 1'b1);
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_SECOND, 1'b1);
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_FIRST, 1'b0);
        send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_SECOND, 1'b0);
        send_item(pmfa_pkg::OP_BYTE, 8'h01, 1'b0);
        send_item(pmfa_pkg::OP_BYTE, 8'h02, 1'b0);
        send_item(pmfa_pkg::OP_RESTART, 8'h00, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);

        // Random: mostly whole frames, some noise, restarts and finalizes
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (sent_count >= CALM_ITEMS)
            begin
                send_idles = 1'b1;
                recv_idles = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 62)
            begin
                send_frame(pick_level(), pick_level(), $urandom_range(0, 99) < 85,
                           $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 85);
            end
            else if (sel < 72)
            begin
                send_item(pmfa_pkg::OP_FINALIZE, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            else if (sel < 84)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    case ($urandom_range(0, 3))
                        0:       nb = pmfa_pkg::HDR_FIRST;
                        1:       nb = pmfa_pkg::HDR_SECOND;
                        2:       nb = pmfa_pkg::TAIL_BYTE;
                        default: nb = 8'($urandom);
                    endcase
                    send_item(pmfa_pkg::OP_BYTE, nb, 1'($urandom_range(0, 1)));
                end
            end
            else if (sel < 92)
            begin
                // Frame cut short by a sensor restart
                send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_FIRST, 1'($urandom_range(0, 1)));
                send_item(pmfa_pkg::OP_BYTE, pmfa_pkg::HDR_SECOND, 1'($urandom_range(0, 1)));
                k = $urandom_range(0, 7);
                repeat (k)
                    send_item(pmfa_pkg::OP_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
                send_item(pmfa_pkg::OP_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            else if (sel < 96)
            begin
                send_item(pmfa_pkg::OP_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_item(pmfa_pkg::OP_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        // Sender pause until everything is out, then a long receiver stall
        drain_results();
        hold_left = HOLD_CYCLES;
        repeat (12)
        begin
            send_frame(pick_level(), pick_level(), 1'b1, 1'b1, 1'b1);
            send_item(pmfa_pkg::OP_FINALIZE, 8'($urandom), 1'b1);
        end
        drain_results();

        // Empty windows, then a two-sample window that counts as an error
        repeat (3)
            send_item(pmfa_pkg::OP_FINALIZE, 8'($urandom), 1'b0);
        send_frame(16'd120, 16'd340, 1'b1, 1'b1, 1'b1);
        send_frame(16'd80, 16'd200, 1'b1, 1'b1, 1'b1);
        send_item(pmfa_pkg::OP_FINALIZE, 8'h00, 1'b0);

        // Wrap up
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run: %0d items in, %0d results checked; %0d good and %0d bad frames",
                 sb.items, sb.checked, sb.good_frames, sb.bad_frames);
        $display("Windows: %0d valid, %0d empty; error count ended at %0d; %0d mismatches",
                 sb.valid_windows, sb.empty_windows, sb.win_errors, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: pm_sensor_frame_averager.f
hdl/pmfa_pkg.sv
hdl/pmfa_front.sv
hdl/pmfa_queue.sv
hdl/pmfa_div.sv
hdl/pmfa_back.sv
hdl/pm_sensor_frame_averager.sv
hdl/pmfa_checker.sv
test/pm_sensor_frame_averager_tb.sv
